/* rtl/twp_pkg.sv */
// Shared types and constants for the three-way partition block.
package twp_pkg;

  localparam int MAX_ITEMS_DEFAULT = 1024;

  localparam int WORD_W   = 32;
  localparam int POS_W    = 10;
  localparam int LESS_W   = 11;
  localparam int STATUS_W = 2;

  // func codes
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // where the returned word comes from
  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_LESS,
    SEL_PIVOT,
    SEL_GREATER
  } sel_t;

  typedef struct packed {
    logic              func;
    logic [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]   value_res;
    logic [POS_W-1:0]    position;
    logic [LESS_W-1:0]   less_total;
    logic                is_last;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  // result fields decided at accept time, completed once RAM data returns
  typedef struct packed {
    sel_t                sel;
    logic [WORD_W-1:0]   pivot;
    logic [POS_W-1:0]    position;
    logic [LESS_W-1:0]   less_total;
    logic                is_last;
    logic [STATUS_W-1:0] status;
  } meta_t;

  typedef struct packed {
    logic less_we;
    logic greater_we;
    logic less_re;
    logic greater_re;
  } mem_ctl_t;

endpackage

/* rtl/twp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module twp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/twp_ctrl.sv */
// Pivot register, set counters and per-transaction classification / RAM addressing.
module twp_ctrl #(
  parameter int MAX_ITEMS = twp_pkg::MAX_ITEMS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_fire,
  input  logic [twp_pkg::WORD_W-1:0]    cfg_data,
  input  logic                          in_fire,
  input  twp_pkg::in_item_t             in_item,
  output twp_pkg::meta_t                meta,
  output twp_pkg::mem_ctl_t             mem_ctl,
  output logic [$clog2(MAX_ITEMS)-1:0]  waddr,
  output logic [$clog2(MAX_ITEMS)-1:0]  raddr
);

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int AW = $clog2(MAX_ITEMS);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

  logic [twp_pkg::WORD_W-1:0] pivot;
  logic [CW-1:0] less_count, less_count_next;
  logic [CW-1:0] greater_count, greater_count_next;
  logic [CW-1:0] item_count, item_count_next;
  logic [CW-1:0] read_index, read_index_next;
  logic          draining, draining_next;

  logic [CW-1:0] base_less, base_greater, base_item;
  logic [CW-1:0] greater_start, greater_off, read_index_inc;

  always_comb begin
    base_less      = draining ? '0 : less_count;
    base_greater   = draining ? '0 : greater_count;
    base_item      = draining ? '0 : item_count;
    greater_start  = item_count - greater_count;
    greater_off    = read_index - greater_start;
    read_index_inc = read_index + 1'b1;

    less_count_next    = less_count;
    greater_count_next = greater_count;
    item_count_next    = item_count;
    read_index_next    = read_index;
    draining_next      = draining;

    mem_ctl = '0;
    waddr   = '0;
    raddr   = '0;

    meta            = '0;
    meta.sel        = twp_pkg::SEL_ZERO;
    meta.pivot      = pivot;
    meta.status     = twp_pkg::STATUS_OK;
    meta.less_total = twp_pkg::LESS_W'(less_count);

    if (in_fire) begin
      if (in_item.func == twp_pkg::FUNC_PUSH) begin
        // first push after a read opens a new set
        less_count_next    = base_less;
        greater_count_next = base_greater;
        item_count_next    = base_item;
        if (draining) begin
          read_index_next = '0;
          draining_next   = 1'b0;
        end
        if (base_item >= MAX_CNT) begin
          meta.status = twp_pkg::STATUS_FULL;
        end else begin
          if (in_item.value < pivot) begin
            mem_ctl.less_we = 1'b1;
            waddr           = base_less[AW-1:0];
            less_count_next = base_less + 1'b1;
          end else if (in_item.value > pivot) begin
            mem_ctl.greater_we = 1'b1;
            waddr              = base_greater[AW-1:0];
            greater_count_next = base_greater + 1'b1;
          end
          item_count_next = base_item + 1'b1;
        end
        meta.less_total = twp_pkg::LESS_W'(less_count_next);
      end else begin
        if (read_index >= item_count) begin
          meta.status   = twp_pkg::STATUS_EMPTY;
          draining_next = 1'b1;
        end else begin
          if (read_index < less_count) begin
            mem_ctl.less_re = 1'b1;
            raddr           = read_index[AW-1:0];
            meta.sel        = twp_pkg::SEL_LESS;
          end else if (read_index < greater_start) begin
            meta.sel = twp_pkg::SEL_PIVOT;
          end else begin
            mem_ctl.greater_re = 1'b1;
            raddr              = greater_off[AW-1:0];
            meta.sel           = twp_pkg::SEL_GREATER;
          end
          meta.position = twp_pkg::POS_W'(read_index);
          if (read_index_inc >= item_count) begin
            // final word: close the set
            meta.is_last       = 1'b1;
            less_count_next    = '0;
            greater_count_next = '0;
            item_count_next    = '0;
            read_index_next    = '0;
            draining_next      = 1'b0;
          end else begin
            read_index_next = read_index_inc;
            draining_next   = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pivot         <= '0;
      less_count    <= '0;
      greater_count <= '0;
      item_count    <= '0;
      read_index    <= '0;
      draining      <= 1'b0;
    end else begin
      if (cfg_fire) begin
        pivot <= cfg_data;
      end
      less_count    <= less_count_next;
      greater_count <= greater_count_next;
      item_count    <= item_count_next;
      read_index    <= read_index_next;
      draining      <= draining_next;
    end
  end

`ifndef ASSERT_OFF
  a_counts_fit: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, less_count} + {1'b0, greater_count}) <= {1'b0, item_count})
    else $error("less and greater counts exceed item count");

  a_item_bound: assert property (@(posedge clk) disable iff (rst)
    item_count <= MAX_CNT && read_index <= item_count)
    else $error("item count or read index out of range");

  a_one_mem_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({mem_ctl.less_we, mem_ctl.greater_we, mem_ctl.less_re, mem_ctl.greater_re}))
    else $error("more than one RAM operation in a cycle");
`endif

endmodule

/* rtl/three_way_partition.sv */
// Top level of the three-way partition block: channels, RAMs and result pipeline.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the 32-bit pivot; always
//   ready. Write it only while no transaction is in flight.
//   in channel carries one transaction per handshake: func 0 pushes value into
//   the set (below pivot -> less RAM, above -> greater RAM, equal -> counted);
//   func 1 reads the next word of the partitioned order.
//   out channel returns exactly one result per accepted transaction, in order.
// Pipeline: a result passes through stage 1 (registered RAM read) and then the
//   output register before it is valid.
// Throughput: one transaction per cycle unless an output stall drops in_ready;
//   each touches at most one RAM port and the counters, which update on accept.
// Reset: clears the pivot, all counts, the read position and both pipeline
//   valids. RAM contents are not cleared; only entries written in the current
//   set are ever read back.
// Stall: when out_ready is low the output register holds; the stage behind it
//   still takes one more transaction if it is free, then in_ready drops until the stall ends.
module three_way_partition #(
  parameter int MAX_ITEMS = twp_pkg::MAX_ITEMS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  // pivot register write
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [twp_pkg::WORD_W-1:0] cfg_data,
  // transactions in
  input  logic                       in_valid,
  output logic                       in_ready,
  input  twp_pkg::in_item_t          in_data,
  // results out
  output logic                       out_valid,
  input  logic                       out_ready,
  output twp_pkg::out_item_t         out_data
);

  localparam int AW = $clog2(MAX_ITEMS);

  logic in_fire, cfg_fire;
  logic s1_valid, s1_move;

  twp_pkg::meta_t    meta, s1_meta;
  twp_pkg::mem_ctl_t mem_ctl;
  logic [AW-1:0]     waddr, raddr;
  logic [twp_pkg::WORD_W-1:0] less_rdata, greater_rdata;
  twp_pkg::out_item_t out_next;

  // Config is always accepted.
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;

  // Stage 1 moves into the output register whenever that register is free
  // or being drained this cycle; input is taken when stage 1 is free or moving.
  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  twp_ctrl #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_fire (cfg_fire),
    .cfg_data (cfg_data),
    .in_fire  (in_fire),
    .in_item  (in_data),
    .meta     (meta),
    .mem_ctl  (mem_ctl),
    .waddr    (waddr),
    .raddr    (raddr)
  );

  // Read data only updates on a read, so it holds while stage 1 is stalled.
  twp_ram #(
    .WIDTH (twp_pkg::WORD_W),
    .DEPTH (MAX_ITEMS)
  ) u_less_ram (
    .clk   (clk),
    .we    (mem_ctl.less_we),
    .waddr (waddr),
    .wdata (in_data.value),
    .re    (mem_ctl.less_re),
    .raddr (raddr),
    .rdata (less_rdata)
  );

  twp_ram #(
    .WIDTH (twp_pkg::WORD_W),
    .DEPTH (MAX_ITEMS)
  ) u_greater_ram (
    .clk   (clk),
    .we    (mem_ctl.greater_we),
    .waddr (waddr),
    .wdata (in_data.value),
    .re    (mem_ctl.greater_re),
    .raddr (raddr),
    .rdata (greater_rdata)
  );

  // Stage 1: result metadata waiting on the RAM read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_meta <= meta;
    end
  end

  // Pick the returned word.
  always_comb begin
    out_next            = '0;
    out_next.position   = s1_meta.position;
    out_next.less_total = s1_meta.less_total;
    out_next.is_last    = s1_meta.is_last;
    out_next.status     = s1_meta.status;
    case (s1_meta.sel)
      twp_pkg::SEL_LESS:    out_next.value_res = less_rdata;
      twp_pkg::SEL_PIVOT:   out_next.value_res = s1_meta.pivot;
      twp_pkg::SEL_GREATER: out_next.value_res = greater_rdata;
      default:              out_next.value_res = '0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data <= out_next;
    end
  end

`ifndef ASSERT_OFF
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(in_fire && s1_valid && !s1_move))
    else $error("stage 1 overwritten while stalled");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_move) |=> (s1_valid && $stable(s1_meta)))
    else $error("stalled stage 1 lost its transaction");

  a_pipe_fills: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> s1_valid)
    else $error("accepted transaction not in stage 1");
`endif

endmodule

/* tb/sv/tb.sv */
// Testbench for three_way_partition: random and directed push/read traffic against a predictor.
`timescale 1ns / 100ps

module tb;

  localparam int SET_MAX = twp_pkg::MAX_ITEMS_DEFAULT;
  localparam int IDX_W   = $clog2(SET_MAX);

  // Clock, reset and channel signals. Every input starts at a known value.
  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [twp_pkg::WORD_W-1:0]   cfg_data  = '0;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  twp_pkg::in_item_t            in_data   = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  twp_pkg::out_item_t           out_data;

  three_way_partition #(
    .MAX_ITEMS(SET_MAX)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Partition predictor: its own copy of the pivot, both stores and the counts.
  // ---------------------------------------------------------------------------
  logic [twp_pkg::WORD_W-1:0] cur_pivot = '0;
  logic [twp_pkg::WORD_W-1:0] below_mem [SET_MAX];
  logic [twp_pkg::WORD_W-1:0] above_mem [SET_MAX];
  int unsigned       n_below  = 0;
  int unsigned       n_above  = 0;
  int unsigned       n_items  = 0;
  int unsigned       rd_ptr   = 0;
  bit                in_drain = 1'b0;

  function automatic void clear_set_model();
    n_below  = 0;
    n_above  = 0;
    n_items  = 0;
    rd_ptr   = 0;
    in_drain = 1'b0;
  endfunction

  // Applies one transaction to the predictor state and returns its result.
  function automatic twp_pkg::out_item_t partition_step(twp_pkg::in_item_t item);
    twp_pkg::out_item_t r;
    int unsigned p;
    int unsigned q;
    int unsigned above_start;
    r = '0;
    if (item.func == twp_pkg::FUNC_PUSH) begin
      // first push after any read opens a fresh set
      if (in_drain) clear_set_model();
      if (n_items >= SET_MAX) begin
        r.status = twp_pkg::STATUS_FULL;
      end else begin
        if (item.value < cur_pivot) begin
          below_mem[n_below[IDX_W-1:0]] = item.value;
          n_below++;
        end else if (item.value > cur_pivot) begin
          above_mem[n_above[IDX_W-1:0]] = item.value;
          n_above++;
        end
        n_items++;
      end
      r.less_total = twp_pkg::LESS_W'(n_below);
    end else begin
      r.less_total = twp_pkg::LESS_W'(n_below);
      if (rd_ptr >= n_items) begin
        r.status = twp_pkg::STATUS_EMPTY;
        in_drain = 1'b1;
      end else begin
        p           = rd_ptr;
        above_start = n_items - n_above;
        q           = p - above_start;
        // equal words come back as the pivot held now, not at push time
        if (p < n_below)          r.value_res = below_mem[p[IDX_W-1:0]];
        else if (p < above_start) r.value_res = cur_pivot;
        else                      r.value_res = above_mem[q[IDX_W-1:0]];
        r.position = p[twp_pkg::POS_W-1:0];
        rd_ptr     = p + 1;
        if (rd_ptr >= n_items) begin
          r.is_last = 1'b1;
          clear_set_model();
        end else begin
          in_drain = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking. Pivot writes, accepted transactions and returned results
  // are all sampled at the rising edge, before the edge's updates land.
  // ---------------------------------------------------------------------------
  twp_pkg::out_item_t pending_results [$];
  twp_pkg::out_item_t oldest;
  int                 errors = 0;

  task automatic check_field(string name, logic [twp_pkg::WORD_W-1:0] want,
                             logic [twp_pkg::WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) cur_pivot = cfg_data;
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
          errors++;
        end else begin
          oldest = pending_results.pop_front();
          check_field("value_res", oldest.value_res, out_data.value_res);
          check_field("position", twp_pkg::WORD_W'(oldest.position),
                      twp_pkg::WORD_W'(out_data.position));
          check_field("less_total", twp_pkg::WORD_W'(oldest.less_total),
                      twp_pkg::WORD_W'(out_data.less_total));
          check_field("is_last", twp_pkg::WORD_W'(oldest.is_last),
                      twp_pkg::WORD_W'(out_data.is_last));
          check_field("status", twp_pkg::WORD_W'(oldest.status),
                      twp_pkg::WORD_W'(out_data.status));
        end
      end
      if (in_valid && in_ready) pending_results.push_back(partition_step(in_data));
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------------------
  bit                         no_stalls  = 1'b0;  // stretch with no idling on either side
  int unsigned                items_sent = 0;
  logic [twp_pkg::WORD_W-1:0] pivot_set  = '0;    // pivot as last written by the stimulus

  // Result side backpressure: ready is dropped with a probability of 11 in 100.
  always @(posedge clk) begin
    if (no_stalls) out_ready <= 1'b1;
    else           out_ready <= ($urandom_range(99) >= 11);
  end

  // Sends one transaction. Valid stays high on return so that a following call
  // in the same step replaces the payload without a low pulse; callers that stop
  // sending go through wait_results, which lowers it.
  task automatic send_item(logic func, logic [twp_pkg::WORD_W-1:0] word);
    if (!no_stalls && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{func: func, value: word};
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic push(logic [twp_pkg::WORD_W-1:0] word);
    send_item(twp_pkg::FUNC_PUSH, word);
  endtask

  // value is ignored on reads, so it carries random bits
  task automatic read_next();
    send_item(twp_pkg::FUNC_READ, $urandom);
  endtask

  // Stops the sender and waits until every expected result has come back.
  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic set_pivot(logic [twp_pkg::WORD_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pivot_set = v;
  endtask

  function automatic logic [twp_pkg::WORD_W-1:0] pick_pivot();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return $urandom_range(64);
      default: return $urandom;
    endcase
  endfunction

  // Words biased toward the pivot and its neighbors so all three classes show up.
  function automatic logic [twp_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      4:       return pivot_set;
      5:       return pivot_set - 1;
      6:       return pivot_set + 1;
      7:       return '0;
      8:       return '1;
      9:       return $urandom_range(pivot_set);
      default: return $urandom;
    endcase
  endfunction

  // Pivot at its reset value of zero: nothing can be below it.
  task automatic test_reset_pivot();
    read_next();           // empty read straight out of reset
    push('0);              // equal, only counted
    push('1);              // greater
    read_next();           // pivot
    read_next();           // greater word, ends the set
    read_next();           // empty again after end of set
    wait_results();
  endtask

  // Mid-range pivot, all three classes, and a new set opened while draining.
  task automatic test_new_set_while_draining();
    set_pivot(32'h8000_0000);
    push('0);
    push('1);
    push(32'h8000_0000);
    push(32'h7FFF_FFFF);
    push(32'h8000_0001);
    read_next();
    read_next();
    push(32'h1234_5678);   // drops the half-read set
    read_next();           // sole word, last
    wait_results();
  endtask

  // Equal words are returned as the pivot in force when they are read.
  task automatic test_pivot_change_mid_set();
    set_pivot(32'd100);
    push(32'd5);
    push(32'd100);
    push(32'd100);
    push(32'd500);
    wait_results();
    set_pivot('1);
    repeat (4) read_next();
    wait_results();
  endtask

  // Fill the set completely with words below the maximum pivot, overflow it,
  // then read the first few words: covers the full flag and less_total 1024.
  // The half-read set is dropped by the next push.
  task automatic test_full_set();
    logic [twp_pkg::WORD_W-1:0] w;
    set_pivot('1);
    repeat (SET_MAX) begin
      w = $urandom;
      if (w == '1) w = '0;
      push(w);
    end
    push($urandom);        // dropped, set full
    push('0);              // dropped as well
    repeat (3) read_next();
    wait_results();
  endtask

  // Mostly well-formed sets (pushes then a full drain) with random content,
  // plus partial drains, reads past the end, stray transactions and pivot changes.
  task automatic test_random_sets();
    int unsigned stop_at;
    int unsigned n;
    int unsigned reads;
    stop_at = items_sent + 250;
    while (items_sent < stop_at) begin
      // idle-free stretch in the middle of the run
      no_stalls = (items_sent + 170 > stop_at) && (items_sent + 70 < stop_at);
      if ($urandom_range(5) == 0) begin
        wait_results();
        set_pivot(pick_pivot());
      end
      n = ($urandom_range(9) == 0) ? $urandom_range(60, 25) : $urandom_range(24, 1);
      repeat (n) begin
        if ($urandom_range(19) == 0) send_item(1'($urandom_range(1)), $urandom);
        else                         push(pick_word());
      end
      // occasionally move the pivot between filling and draining
      if ($urandom_range(7) == 0) begin
        wait_results();
        set_pivot(pick_pivot());
      end
      case ($urandom_range(9))
        0, 1:    reads = $urandom_range(n);
        2:       reads = n + $urandom_range(3, 1);
        default: reads = n;
      endcase
      repeat (reads) read_next();
    end
    no_stalls = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_pivot();
    test_new_set_while_draining();
    test_pivot_change_mid_set();
    test_full_set();
    test_random_sets();
    wait_results();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
